// File: sv/clkswp_pkg.sv
// Package: shared types and codes for the clock swap manager.
package clkswp_pkg;

    localparam int unsigned OP_W = 2;

    localparam logic [1:0] OP_ACCESS   = 2'd0;
    localparam logic [1:0] OP_SWAP_OUT = 2'd1;
    localparam logic [1:0] OP_SWAP_IN  = 2'd2;
    localparam logic [1:0] OP_FREE_ALL = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NO_SWAP   = 2'd2;
    localparam logic [1:0] ST_NO_VICTIM = 2'd3;

    localparam logic [1:0] REG_FRAMES  = 2'd0;
    localparam logic [1:0] REG_SLOTS   = 2'd1;
    localparam logic [1:0] REG_SPP     = 2'd2;
    localparam logic [1:0] REG_SPT     = 2'd3;

    localparam int unsigned FLAG_REF   = 0;
    localparam int unsigned FLAG_DIRTY = 1;
    localparam int unsigned FLAG_BUSY  = 2;

    localparam int unsigned CFG_W = 11;

    typedef struct packed {
        logic [1:0] op;
        logic [5:0] frame_index;
        logic [5:0] owner_pid;
        logic [7:0] page_number;
        logic       is_write;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  victim_frame;
        logic        needs_writeback;
        logic        slot_found;
        logic [13:0] disk_track;
        logic [9:0]  disk_sector;
    } t_out;

endpackage

// File: sv/clock_swap_manager_unit.sv
// Clock swap manager: frame and swap slot tables under a small sequencer.
// Access reads then writes the frame; swap-in writes the frame and scans the slots; swap-out
// steps the hand up to 2 x frame count times, then scans the slots when the victim is dirty.
// A found or claimed slot's sector offset is then divided by sectors per track, one quotient bit per cycle.
// One item at a time, next accepted in the cycle after o_valid; o_valid lasts one cycle.
// Reset clears both tables in one pass over max(MAX_FRAMES, MAX_SLOTS) entries; busy meanwhile.
module clock_swap_manager_unit
    import clkswp_pkg::*;
#(
    parameter int unsigned MAX_FRAMES = 64,
    parameter int unsigned MAX_SLOTS  = 256,
    parameter int unsigned PID_BITS   = 6,
    parameter int unsigned PAGE_BITS  = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in              i_in,
    output logic             o_valid,
    output t_out             o_result,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int unsigned FA   = $clog2(MAX_FRAMES);
    localparam int unsigned SA   = $clog2(MAX_SLOTS);
    localparam int unsigned KW   = PID_BITS + PAGE_BITS;
    localparam int unsigned DW   = SA + 7;
    localparam int unsigned DCW  = $clog2(DW + 1);
    localparam int unsigned MAXN = (MAX_FRAMES > MAX_SLOTS) ? MAX_FRAMES : MAX_SLOTS;
    localparam int unsigned CW   = $clog2(MAXN);

    typedef enum logic [15:0] {
        S_CLEAR  = 16'h0001,
        S_IDLE   = 16'h0002,
        S_ACC_RD = 16'h0004,
        S_ACC_WR = 16'h0008,
        S_SO_ADV = 16'h0010,
        S_SO_CHK = 16'h0020,
        S_SI_RD  = 16'h0040,
        S_SI_WR  = 16'h0080,
        S_SC_RD  = 16'h0100,
        S_SC_CHK = 16'h0200,
        S_SC_END = 16'h0400,
        S_FA_RD  = 16'h0800,
        S_FA_CHK = 16'h1000,
        S_DP_MUL = 16'h2000,
        S_DP_DIV = 16'h4000,
        S_DONE   = 16'h8000
    } t_state;

    t_state r_state, n_state;

    logic [6:0]  r_frames_cfg;
    logic [8:0]  r_slots_cfg;
    logic [6:0]  r_spp;
    logic [10:0] r_spt_cfg;

    logic [FA-1:0]  r_hand, n_hand;
    logic [FA+1:0]  r_step, n_step;
    logic [SA:0]    r_idx, n_idx;
    logic [SA-1:0]  r_free, n_free;
    logic           r_free_ok, n_free_ok;
    logic [SA-1:0]  r_slot, n_slot;
    logic [KW-1:0]  r_key, n_key;
    logic [1:0]     r_op, n_op;
    logic [FA-1:0]  r_frame, n_frame;
    logic           r_frame_ok, n_frame_ok;
    logic           r_wr, n_wr;
    t_out           r_res, n_res;
    logic [DW-1:0]  r_quo, n_quo;
    logic [9:0]     r_rem, n_rem;
    logic [DCW-1:0] r_cnt, n_cnt;
    logic [CW-1:0]  r_clr, n_clr;

    logic [KW+2:0] r_fmem [MAX_FRAMES];
    logic [KW+2:0] r_frame_rd;
    logic          fm_we;
    logic [FA-1:0] fm_waddr, fm_raddr;
    logic [KW+2:0] fm_wdata;

    logic [KW:0]   r_smem [MAX_SLOTS];
    logic [KW:0]   r_slot_rd;
    logic          sm_we;
    logic [SA-1:0] sm_waddr, sm_raddr;
    logic [KW:0]   sm_wdata;

    logic [10:0]    f_ext, nf;
    logic [FA:0]    nframes;
    logic [FA+1:0]  two_n;
    logic [12:0]    s_ext, ns;
    logic [SA:0]    scount;
    logic [10:0]    spt;
    logic [FA:0]    hand_inc;
    logic [FA-1:0]  hand_next;
    logic [10:0]    fin_ext;
    logic [15:0]    pid_ext;
    logic [19:0]    page_ext;
    logic [KW-1:0]  in_key;
    logic [2:0]     fflags;
    logic [10:0]    trial;
    logic [DW+13:0] quo_ext;
    logic [15:0]    hand_ext;

    always_comb begin
        f_ext = {4'b0, r_frames_cfg};
        if (f_ext == 11'd0) begin
            nf = 11'd1;
        end else if (f_ext > 11'(MAX_FRAMES)) begin
            nf = 11'(MAX_FRAMES);
        end else begin
            nf = f_ext;
        end
        nframes = nf[FA:0];
        two_n   = {nframes, 1'b0};
        s_ext   = {4'b0, r_slots_cfg};
        ns      = (s_ext > 13'(MAX_SLOTS)) ? 13'(MAX_SLOTS) : s_ext;
        scount  = ns[SA:0];
        if (r_spt_cfg == 11'd0) begin
            spt = 11'd1;
        end else if (r_spt_cfg > 11'd1024) begin
            spt = 11'd1024;
        end else begin
            spt = r_spt_cfg;
        end
        hand_inc  = {1'b0, r_hand} + 1'b1;
        hand_next = (hand_inc >= nframes) ? '0 : hand_inc[FA-1:0];
        fin_ext   = {5'b0, i_in.frame_index};
        pid_ext   = {10'b0, i_in.owner_pid};
        page_ext  = {12'b0, i_in.page_number};
        in_key    = {pid_ext[PID_BITS-1:0], page_ext[PAGE_BITS-1:0]};
        fflags    = r_frame_rd[2:0];
        trial     = {r_rem, r_quo[DW-1]};
        quo_ext   = {{14{1'b0}}, r_quo};
        hand_ext  = 16'(r_hand);
    end

    always_comb begin
        n_state    = r_state;
        n_hand     = r_hand;
        n_step     = r_step;
        n_idx      = r_idx;
        n_free     = r_free;
        n_free_ok  = r_free_ok;
        n_slot     = r_slot;
        n_key      = r_key;
        n_op       = r_op;
        n_frame    = r_frame;
        n_frame_ok = r_frame_ok;
        n_wr       = r_wr;
        n_res      = r_res;
        n_quo      = r_quo;
        n_rem      = r_rem;
        n_cnt      = r_cnt;
        n_clr      = r_clr;
        fm_we      = 1'b0;
        fm_waddr   = r_frame;
        fm_raddr   = r_frame;
        fm_wdata   = r_frame_rd;
        sm_we      = 1'b0;
        sm_waddr   = r_idx[SA-1:0];
        sm_raddr   = r_idx[SA-1:0];
        sm_wdata   = '0;
        case (r_state)
            S_CLEAR: begin
                fm_we    = ({1'b0, r_clr} < (CW+1)'(MAX_FRAMES));
                fm_waddr = r_clr[FA-1:0];
                fm_wdata = '0;
                sm_we    = ({1'b0, r_clr} < (CW+1)'(MAX_SLOTS));
                sm_waddr = r_clr[SA-1:0];
                sm_wdata = '0;
                n_clr    = r_clr + 1'b1;
                if (r_clr == CW'(MAXN - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_op       = i_in.op;
                    n_frame    = fin_ext[FA-1:0];
                    n_frame_ok = (fin_ext < 11'(MAX_FRAMES));
                    n_wr       = i_in.is_write;
                    n_key      = in_key;
                    n_res      = '0;
                    n_idx      = '0;
                    n_step     = '0;
                    n_free_ok  = 1'b0;
                    case (i_in.op)
                        OP_ACCESS:   n_state = S_ACC_RD;
                        OP_SWAP_OUT: n_state = S_SO_ADV;
                        OP_SWAP_IN:  n_state = S_SI_RD;
                        OP_FREE_ALL: n_state = S_FA_RD;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_ACC_RD: begin
                n_state = r_frame_ok ? S_ACC_WR : S_DONE;
            end
            S_ACC_WR: begin
                fm_we = 1'b1;
                fm_wdata[FLAG_REF] = 1'b1;
                if (r_wr) begin
                    fm_wdata[FLAG_DIRTY] = 1'b1;
                end
                n_state = S_DONE;
            end
            S_SO_ADV: begin
                if (r_step == two_n) begin
                    n_res.status = ST_NO_VICTIM;
                    n_state      = S_DONE;
                end else begin
                    n_hand   = hand_next;
                    fm_raddr = hand_next;
                    n_step   = r_step + 1'b1;
                    n_state  = S_SO_CHK;
                end
            end
            S_SO_CHK: begin
                fm_waddr = r_hand;
                if (fflags[FLAG_BUSY]) begin
                    n_state = S_SO_ADV;
                end else if (fflags[FLAG_REF]) begin
                    fm_we = 1'b1;
                    fm_wdata[FLAG_REF] = 1'b0;
                    n_state = S_SO_ADV;
                end else begin
                    fm_we = 1'b1;
                    fm_wdata[FLAG_BUSY]  = 1'b1;
                    fm_wdata[FLAG_DIRTY] = 1'b0;
                    n_res.victim_frame = hand_ext[5:0];
                    if (fflags[FLAG_DIRTY]) begin
                        n_res.needs_writeback = 1'b1;
                        n_key   = r_frame_rd[KW+2:3];
                        n_state = S_SC_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SI_RD: begin
                n_state = r_frame_ok ? S_SI_WR : S_SC_RD;
            end
            S_SI_WR: begin
                fm_we    = 1'b1;
                fm_wdata = {r_key, fflags};
                fm_wdata[FLAG_BUSY] = 1'b0;
                n_state  = S_SC_RD;
            end
            S_SC_RD: begin
                n_state = (r_idx >= scount) ? S_SC_END : S_SC_CHK;
            end
            S_SC_CHK: begin
                if (r_slot_rd[KW] && r_slot_rd[KW-1:0] == r_key) begin
                    n_slot = r_idx[SA-1:0];
                    n_res.slot_found = 1'b1;
                    n_state = S_DP_MUL;
                end else begin
                    if (!r_slot_rd[KW] && !r_free_ok) begin
                        n_free    = r_idx[SA-1:0];
                        n_free_ok = 1'b1;
                    end
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SC_RD;
                end
            end
            S_SC_END: begin
                if (r_op == OP_SWAP_IN) begin
                    if (r_free_ok) begin
                        sm_we    = 1'b1;
                        sm_waddr = r_free;
                        sm_wdata = {1'b1, r_key};
                        n_slot   = r_free;
                        n_res.status     = ST_EMPTY;
                        n_res.slot_found = 1'b1;
                        n_state  = S_DP_MUL;
                    end else begin
                        n_res.status = ST_NO_SWAP;
                        n_state      = S_DONE;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FA_RD: begin
                n_state = (r_idx == (SA+1)'(MAX_SLOTS)) ? S_DONE : S_FA_CHK;
            end
            S_FA_CHK: begin
                if (r_slot_rd[KW] && r_slot_rd[KW-1:PAGE_BITS] == r_key[KW-1:PAGE_BITS]) begin
                    sm_we = 1'b1;
                end
                n_idx   = r_idx + 1'b1;
                n_state = S_FA_RD;
            end
            S_DP_MUL: begin
                n_quo   = DW'(r_slot) * DW'(r_spp);
                n_rem   = '0;
                n_cnt   = DCW'(DW);
                n_state = S_DP_DIV;
            end
            S_DP_DIV: begin
                if (r_cnt == '0) begin
                    n_res.disk_track  = quo_ext[13:0];
                    n_res.disk_sector = r_rem;
                    n_state = S_DONE;
                end else begin
                    if (trial >= spt) begin
                        n_rem = 10'(trial - spt);
                        n_quo = {r_quo[DW-2:0], 1'b1};
                    end else begin
                        n_rem = trial[9:0];
                        n_quo = {r_quo[DW-2:0], 1'b0};
                    end
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (fm_we) begin
            r_fmem[fm_waddr] <= fm_wdata;
        end
        r_frame_rd <= r_fmem[fm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (sm_we) begin
            r_smem[sm_waddr] <= sm_wdata;
        end
        r_slot_rd <= r_smem[sm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_hand       <= FA'(MAX_FRAMES - 1);
            r_clr        <= '0;
            r_frames_cfg <= 7'd64;
            r_slots_cfg  <= 9'd256;
            r_spp        <= 7'd8;
            r_spt_cfg    <= 11'd16;
        end else begin
            r_state <= n_state;
            r_hand  <= n_hand;
            r_clr   <= n_clr;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FRAMES: r_frames_cfg <= i_cfg_data[6:0];
                    REG_SLOTS:  r_slots_cfg  <= i_cfg_data[8:0];
                    REG_SPP:    r_spp        <= i_cfg_data[6:0];
                    REG_SPT:    r_spt_cfg    <= i_cfg_data;
                    default:    r_spp        <= r_spp;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_step     <= n_step;
        r_idx      <= n_idx;
        r_free     <= n_free;
        r_free_ok  <= n_free_ok;
        r_slot     <= n_slot;
        r_key      <= n_key;
        r_op       <= n_op;
        r_frame    <= n_frame;
        r_frame_ok <= n_frame_ok;
        r_wr       <= n_wr;
        r_res      <= n_res;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = (r_state == S_DONE);
    assign o_result = r_res;

`ifndef SYNTH
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("item accepted but block not busy");
    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.slot_found) |-> (o_result.status == ST_OK ||
        o_result.status == ST_EMPTY)) else $error("slot found with failure status");
    a_no_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ST_NO_VICTIM) |-> !o_result.needs_writeback)
        else $error("writeback without victim");
`endif

endmodule

// File: tb/tb_top.sv
// Testbench for clock_swap_manager_unit: random and directed items checked against a predictor.
module tb_top;
    import clkswp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    class swap_scoreboard;
        int unsigned frames_cfg, slots_cfg, spp_cfg, spt_cfg;
        int unsigned hand;
        bit [2:0]    flags [64];
        bit [13:0]   frame_key [64];
        bit          frame_filled [64];
        bit          slot_used [256];
        bit [13:0]   slot_key [256];
        t_out        expected_q [$];
        int unsigned errors;

        function new();
            frames_cfg = 64;
            slots_cfg  = 256;
            spp_cfg    = 8;
            spt_cfg    = 16;
            hand       = 63;
            errors     = 0;
            foreach (flags[i]) begin
                flags[i] = '0;
                frame_filled[i] = 0;
            end
            foreach (slot_used[i]) slot_used[i] = 0;
        endfunction

        function void set_reg(logic [1:0] idx, int unsigned val);
            case (idx)
                REG_FRAMES: frames_cfg = val & 'h7F;
                REG_SLOTS:  slots_cfg  = val & 'h1FF;
                REG_SPP:    spp_cfg    = val & 'h7F;
                default:    spt_cfg    = val & 'h7FF;
            endcase
        endfunction

        function int unsigned frame_limit();
            if (frames_cfg < 1) return 1;
            if (frames_cfg > 64) return 64;
            return frames_cfg;
        endfunction

        function int unsigned slot_limit();
            return (slots_cfg > 256) ? 256 : slots_cfg;
        endfunction

        function int find_slot(bit [13:0] key);
            for (int i = 0; i < slot_limit(); i++)
                if (slot_used[i] && slot_key[i] == key) return i;
            return -1;
        endfunction

        function void place(int unsigned slot, ref t_out r);
            int unsigned spt, first;
            spt = (spt_cfg < 1) ? 1 : (spt_cfg > 1024) ? 1024 : spt_cfg;
            first = slot * spp_cfg;
            r.slot_found = 1'b1;
            r.disk_track = 14'((first / spt) & 'h3FFF);
            r.disk_sector = 10'(first % spt);
        endfunction

        function void note_item(t_in x);
            t_out        r;
            int          sl, victim;
            int unsigned n, h, f;
            bit [13:0]   key;
            r = '0;
            f = x.frame_index;
            key = {x.owner_pid, x.page_number};
            case (x.op)
                OP_ACCESS: begin
                    flags[f][FLAG_REF] = 1'b1;
                    if (x.is_write) flags[f][FLAG_DIRTY] = 1'b1;
                end
                OP_SWAP_OUT: begin
                    n = frame_limit();
                    victim = -1;
                    for (int s = 0; s < 2 * n; s++) begin
                        h = hand + 1;
                        if (h >= n) h = 0;
                        hand = h;
                        if (flags[h][FLAG_BUSY]) continue;
                        if (flags[h][FLAG_REF]) flags[h][FLAG_REF] = 1'b0;
                        else begin
                            victim = h;
                            break;
                        end
                    end
                    if (victim < 0) r.status = ST_NO_VICTIM;
                    else begin
                        r.victim_frame = 6'(victim);
                        if (flags[victim][FLAG_DIRTY]) begin
                            r.needs_writeback = 1'b1;
                            sl = find_slot(frame_key[victim]);
                            if (sl >= 0) place(sl, r);
                            flags[victim][FLAG_DIRTY] = 1'b0;
                        end
                        flags[victim][FLAG_BUSY] = 1'b1;
                    end
                end
                OP_SWAP_IN: begin
                    frame_key[f] = key;
                    frame_filled[f] = 1;
                    sl = find_slot(key);
                    if (sl >= 0) place(sl, r);
                    else begin
                        sl = -1;
                        for (int i = 0; i < slot_limit(); i++)
                            if (!slot_used[i]) begin
                                sl = i;
                                break;
                            end
                        if (sl >= 0) begin
                            slot_used[sl] = 1;
                            slot_key[sl] = key;
                            r.status = ST_EMPTY;
                            place(sl, r);
                        end else r.status = ST_NO_SWAP;
                    end
                    flags[f][FLAG_BUSY] = 1'b0;
                end
                default: begin
                    foreach (slot_used[i])
                        if (slot_used[i] && slot_key[i][13:8] == x.owner_pid) slot_used[i] = 0;
                end
            endcase
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            $display("%0t ns  mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_out got);
            t_out want;
            if (expected_q.size() == 0) begin
                report("result with no item outstanding");
                return;
            end
            want = expected_q.pop_front();
            if (got.status != want.status)
                report($sformatf("status %0d want %0d", got.status, want.status));
            if (got.victim_frame != want.victim_frame)
                report($sformatf("victim %0d want %0d", got.victim_frame, want.victim_frame));
            if (got.needs_writeback != want.needs_writeback)
                report($sformatf("writeback %0d want %0d", got.needs_writeback,
                                 want.needs_writeback));
            if (got.slot_found != want.slot_found)
                report($sformatf("slot_found %0d want %0d", got.slot_found, want.slot_found));
            if (got.disk_track != want.disk_track)
                report($sformatf("track %0d want %0d", got.disk_track, want.disk_track));
            if (got.disk_sector != want.disk_sector)
                report($sformatf("sector %0d want %0d", got.disk_sector, want.disk_sector));
        endtask
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_in              i_in;
    logic             o_valid;
    t_out             o_result;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    swap_scoreboard sb;

    clock_swap_manager_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_result);
    end

    task send_item(t_in x);
        i_in  <= x;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_item(x);
    endtask

    task hold_off(int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task write_reg(logic [1:0] idx, int unsigned val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(val);
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    function t_in make_item(logic [1:0] op, int unsigned f, int unsigned pid,
                            int unsigned pg, bit wr);
        t_in x;
        x.op = op;
        x.frame_index = 6'(f);
        x.owner_pid = 6'(pid);
        x.page_number = 8'(pg);
        x.is_write = wr && sb.frame_filled[f];
        return x;
    endfunction

    function t_in random_item();
        int unsigned pick, f, pid, pg;
        logic [1:0]  op;
        pick = $urandom_range(0, 99);
        op = (pick < 35) ? OP_ACCESS : (pick < 60) ? OP_SWAP_OUT :
             (pick < 92) ? OP_SWAP_IN : OP_FREE_ALL;
        f = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                        : $urandom_range(0, sb.frame_limit() - 1);
        pid = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 3);
        pg = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
        return make_item(op, f, pid, pg, $urandom_range(0, 1));
    endfunction

    int unsigned phase_cfg [8][4] = '{
        '{1, 1, 1, 1}, '{64, 256, 64, 1024}, '{0, 0, 0, 0}, '{127, 511, 127, 2047},
        '{8, 4, 3, 7}, '{16, 32, 5, 1000}, '{2, 300, 64, 1}, '{64, 16, 8, 16}
    };

    initial begin
        int unsigned burst;
        sb = new();
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_in       <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= REG_FRAMES;
        i_cfg_data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);

        send_item(make_item(OP_SWAP_IN, 0, 0, 0, 0));
        send_item(make_item(OP_SWAP_IN, 0, 0, 0, 0));
        send_item(make_item(OP_ACCESS, 0, 0, 0, 1));
        send_item(make_item(OP_SWAP_IN, 63, 63, 255, 0));
        send_item(make_item(OP_ACCESS, 63, 0, 0, 1));
        send_item(make_item(OP_ACCESS, 5, 0, 0, 0));
        send_item(make_item(OP_SWAP_OUT, 0, 0, 0, 0));
        send_item(make_item(OP_SWAP_OUT, 0, 0, 0, 0));
        send_item(make_item(OP_SWAP_IN, 1, 0, 1, 0));
        send_item(make_item(OP_ACCESS, 1, 0, 0, 1));
        send_item(make_item(OP_FREE_ALL, 0, 63, 0, 0));
        send_item(make_item(OP_SWAP_IN, 62, 63, 128, 0));
        send_item(make_item(OP_FREE_ALL, 0, 0, 0, 0));
        send_item(make_item(OP_SWAP_OUT, 0, 0, 0, 0));
        send_item(make_item(OP_SWAP_OUT, 0, 0, 0, 0));
        send_item(make_item(OP_SWAP_IN, 2, 42, 170, 0));
        send_item(make_item(OP_ACCESS, 2, 0, 0, 1));
        send_item(make_item(OP_FREE_ALL, 0, 21, 0, 0));

        foreach (phase_cfg[p]) begin
            drain();
            write_reg(REG_FRAMES, phase_cfg[p][0]);
            write_reg(REG_SLOTS, phase_cfg[p][1]);
            write_reg(REG_SPP, phase_cfg[p][2]);
            write_reg(REG_SPT, phase_cfg[p][3]);
            i_cfg_we <= 1'b0;
            for (int k = 0; k < 100; k += burst) begin
                burst = $urandom_range(1, 20);
                repeat (burst) send_item(random_item());
                if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 8));
            end
        end

        drain();
        repeat (1200) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("clock_swap_manager_unit regression: pass");
        else
            $display("clock_swap_manager_unit regression: fail");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("clock_swap_manager_unit regression: fail");
        $finish;
    end
endmodule

// File: files.f
sv/clkswp_pkg.sv
sv/clock_swap_manager_unit.sv
tb/tb_top.sv
